### hw/rtl/wgm_pkg.sv
`timescale 1ns / 1ps
// Wildcard glob matcher: shared constants, types and helper functions.
// Depends on nothing; used by every other file of the block.
package wgm_pkg;

    localparam int PATTERN_DEPTH = 32;
    localparam int CHAR_BITS     = 16;
    localparam int IDX_W         = 5;
    localparam int LEN_W         = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 6;

    localparam logic [31:0] STAR_CODE  = 32'h0000_002A;
    localparam logic [31:0] QUERY_CODE = 32'h0000_003F;
    localparam logic [31:0] END_CODE   = 32'h0000_0000;

    typedef enum logic [1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH   = 2'd0,
        REG_CASE_INSENSITIVE = 2'd1
    } t_reg_idx;

    // Per-transaction controls broadcast to every cell
    typedef struct packed {
        logic write;
        logic step;
        logic rearm;
        logic fold_en;
    } t_cell_ctl;

    // Signals rippled from one cell to the next
    typedef struct packed {
        logic live;    // position is inside the pattern in effect
        logic pre_c;   // star closure before the step
        logic hit;     // character consumed, activates the next position
        logic post_c;  // star closure after the step
    } t_link;

    function automatic logic [31:0] fold_char(input logic [31:0] c, input logic en);
        logic [31:0] r;
        r = c;
        if (en && c >= 32'h41 && c <= 32'h5A) begin
            r = c + 32'h20;
        end
        return r;
    endfunction

endpackage

### hw/rtl/wgm_if.sv
`timescale 1ns / 1ps
// Wildcard glob matcher: valid/ready channel interfaces for input items and results.
// Depends on wgm_pkg for field widths.
interface wgm_in_if #(
    parameter int CHAR_BITS = wgm_pkg::CHAR_BITS
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [wgm_pkg::IDX_W-1:0]   pattern_index;
    logic [CHAR_BITS-1:0]        char_value;

    modport source (output valid, kind, pattern_index, char_value, input ready);
    modport sink   (input valid, kind, pattern_index, char_value, output ready);
endinterface

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

### hw/rtl/wgm_cell.sv
`timescale 1ns / 1ps
// Wildcard glob matcher: one pattern position (stored character and active bit).
// Depends on wgm_pkg; instantiated in a row by wildcard_glob_matcher.
module wgm_cell #(
    parameter int POS       = 0,
    parameter int CHAR_BITS = wgm_pkg::CHAR_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wgm_pkg::t_cell_ctl        i_ctl,
    input  logic [wgm_pkg::IDX_W-1:0] i_wr_idx,
    input  logic [CHAR_BITS-1:0]      i_char,
    input  logic [31:0]               i_char_fold,
    input  logic                      i_in_range,
    input  wgm_pkg::t_link            i_link,
    output wgm_pkg::t_link            o_link,
    output logic                      o_end
);

    logic [CHAR_BITS-1:0] r_entry;
    logic                 r_act;

    logic is_star, is_query, is_zero, live, pre, nxt, post, eq;

    always_comb begin
        is_star  = (32'(r_entry) == wgm_pkg::STAR_CODE);
        is_query = (32'(r_entry) == wgm_pkg::QUERY_CODE);
        is_zero  = (32'(r_entry) == wgm_pkg::END_CODE);
        eq       = (wgm_pkg::fold_char(32'(r_entry), i_ctl.fold_en) == i_char_fold);
        live     = i_link.live & i_in_range & ~is_zero;
        pre      = r_act | i_link.pre_c;
        nxt      = (pre & is_star & live) | i_link.hit;
        post     = nxt | i_link.post_c;

        o_link.live   = live;
        o_link.pre_c  = pre & is_star & live;
        o_link.hit    = pre & live & ~is_star & (is_query | eq);
        o_link.post_c = post & is_star & live;
        // first position past the pattern in effect
        o_end         = i_link.live & ~live & pre;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (32'(i_wr_idx) == 32'(POS))) begin
            r_entry <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'(POS == 0);
        end else if (i_ctl.rearm) begin
            r_act <= 1'(POS == 0);
        end else if (i_ctl.step) begin
            r_act <= post;
        end
    end

endmodule

### hw/rtl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// Wildcard glob matcher top level: config registers, cell row and result register.
// Depends on wgm_pkg, wgm_if (wgm_in_if, wgm_out_if) and wgm_cell.
//
//  Port      Dir  Handshake    Payload
//  i_item    in   valid/ready  kind, pattern_index, char_value
//  o_result  out  valid/ready  matched
//  i_cfg_*   in   write enable register index, data
//
// One transaction per cycle; every item is handled in the cycle it is accepted.
// The active set ripples through the cell row in that cycle (one cell per position).
// An end item's result sits in one output register; input stalls only while that
// register is full and not being taken. Synchronous active-low reset; no clearing pass.
module wildcard_glob_matcher #(
    parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH,
    parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wgm_in_if.sink                         i_item,
    wgm_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wgm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [wgm_pkg::LEN_W-1:0] r_pattern_length;
    logic                      r_case_insensitive;
    logic                      r_tail;
    logic                      r_out_valid;
    logic                      r_matched;

    wgm_pkg::t_cell_ctl       w_ctl;
    wgm_pkg::t_link           w_link [PATTERN_DEPTH:0];
    logic [PATTERN_DEPTH-1:0] w_in_range;
    logic [PATTERN_DEPTH-1:0] w_end;
    logic [31:0]              w_char_fold;
    logic                     w_in_accept;
    logic                     w_end_tail;
    logic                     w_result;
    logic                     w_tail_post;

    assign i_item.ready   = ~r_out_valid | o_result.ready;
    assign w_in_accept    = i_item.valid & i_item.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.matched = r_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length   <= '0;
            r_case_insensitive <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wgm_pkg::REG_PATTERN_LENGTH:   r_pattern_length   <= i_cfg_data;
                wgm_pkg::REG_CASE_INSENSITIVE: r_case_insensitive <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ctl         = '0;
        w_ctl.fold_en = r_case_insensitive;
        if (w_in_accept) begin
            unique case (i_item.kind)
                wgm_pkg::KIND_PATTERN: w_ctl.write = 1'b1;
                wgm_pkg::KIND_TEXT:    w_ctl.step  = 1'b1;
                wgm_pkg::KIND_END:     w_ctl.rearm = 1'b1;
                default: ;
            endcase
        end
    end

    assign w_char_fold = wgm_pkg::fold_char(32'(i_item.char_value), r_case_insensitive);
    assign w_link[0]   = '{live: 1'b1, pre_c: 1'b0, hit: 1'b0, post_c: 1'b0};

    for (genvar g = 0; g < PATTERN_DEPTH; g++) begin : g_cell
        assign w_in_range[g] = (32'(g) < 32'(r_pattern_length));

        wgm_cell #(
            .POS       (g),
            .CHAR_BITS (CHAR_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_wr_idx    (i_item.pattern_index),
            .i_char      (i_item.char_value),
            .i_char_fold (w_char_fold),
            .i_in_range  (w_in_range[g]),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .o_end       (w_end[g])
        );
    end

    // position PATTERN_DEPTH holds no character, only an active bit
    assign w_end_tail  = w_link[PATTERN_DEPTH].live & (r_tail | w_link[PATTERN_DEPTH].pre_c);
    assign w_tail_post = w_link[PATTERN_DEPTH].hit | w_link[PATTERN_DEPTH].post_c;
    assign w_result    = (|w_end) | w_end_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
        end else if (w_ctl.rearm) begin
            r_tail <= 1'b0;
        end else if (w_ctl.step) begin
            r_tail <= w_tail_post;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.rearm) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.rearm) begin
            r_matched <= w_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !w_in_accept)
        else $error("transaction accepted while result register full");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_ctl.rearm) |=> r_out_valid)
        else $error("end transaction produced no result");

    a_rearm_clears_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_ctl.rearm) |=> !r_tail)
        else $error("rearm left final position active");

    a_single_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rearm |-> $onehot0({w_end, w_end_tail}))
        else $error("more than one pattern end position");
`endif

endmodule
